[design/integer_stack_machine_step_unit_defines.svh]
`ifndef INTEGER_STACK_MACHINE_STEP_UNIT_DEFINES_SVH
`define INTEGER_STACK_MACHINE_STEP_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ISM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ISM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ism_pkg.sv]
package ism_pkg;

  localparam int STACK_DEPTH_DEF = 256;
  localparam int LOCAL_DEPTH_DEF = 256;
  localparam logic [15:0] PLEN_RESET = 16'hFFFF;

  localparam logic [15:0] OP_PUSH       = 16'h0001;
  localparam logic [15:0] OP_PUSH2      = 16'h0002;
  localparam logic [15:0] OP_STR03      = 16'h0003;
  localparam logic [15:0] OP_POP        = 16'h0005;
  localparam logic [15:0] OP_ADD        = 16'h0006;
  localparam logic [15:0] OP_SUB        = 16'h0007;
  localparam logic [15:0] OP_MUL        = 16'h0008;
  localparam logic [15:0] OP_DIV        = 16'h0009;
  localparam logic [15:0] OP_SHOW_TOP   = 16'h000A;
  localparam logic [15:0] OP_READ_IN    = 16'h000B;
  localparam logic [15:0] OP_SAVE_LOCAL = 16'h000C;
  localparam logic [15:0] OP_LOAD       = 16'h000D;
  localparam logic [15:0] OP_CMP        = 16'h000E;
  localparam logic [15:0] OP_JMP        = 16'h000F;
  localparam logic [15:0] OP_JNZ        = 16'h0010;
  localparam logic [15:0] OP_JZ         = 16'h0011;
  localparam logic [15:0] OP_JNE        = 16'h0012;
  localparam logic [15:0] OP_JE         = 16'h0013;
  localparam logic [15:0] OP_JGE        = 16'h0014;
  localparam logic [15:0] OP_JG         = 16'h0015;
  localparam logic [15:0] OP_JLE        = 16'h0016;
  localparam logic [15:0] OP_JL         = 16'h0017;
  localparam logic [15:0] OP_AND        = 16'h0018;
  localparam logic [15:0] OP_OR         = 16'h0019;
  localparam logic [15:0] OP_NOT        = 16'h001A;
  localparam logic [15:0] OP_NOP1B      = 16'h001B;
  localparam logic [15:0] OP_NOP1C      = 16'h001C;
  localparam logic [15:0] OP_STR1D      = 16'h001D;
  localparam logic [15:0] OP_NOP1F      = 16'h001F;
  localparam logic [15:0] OP_SHOW20     = 16'h0020;
  localparam logic [15:0] OP_SHOW21     = 16'h0021;
  localparam logic [15:0] OP_NOP22      = 16'h0022;
  localparam logic [15:0] OP_NOP23      = 16'h0023;
  localparam logic [15:0] OP_HALT       = 16'hFFFF;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_OVER  = 3'd1;
  localparam logic [2:0] ST_UNDER = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_LOCAL = 3'd4;
  localparam logic [2:0] ST_JUMP  = 3'd5;
  localparam logic [2:0] ST_UNSUP = 3'd6;

  localparam logic [1:0] FLAG_EQ = 2'd0;
  localparam logic [1:0] FLAG_GT = 2'd1;
  localparam logic [1:0] FLAG_LT = 2'd2;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV
  } state_t;

  typedef struct packed {
    logic        [15:0] req_type;
    logic signed [31:0] operand;
    logic signed [31:0] input_value;
  } in_item_t;

  typedef struct packed {
    logic        [2:0]  status;
    logic        [15:0] next_line;
    logic               halted;
    logic               show_valid;
    logic signed [31:0] show_value;
    logic        [8:0]  stack_count;
  } out_item_t;

endpackage

[design/ism_ram.sv]
module ism_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/ism_div.sv]
module ism_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        neg_r, neg_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [32:0] rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r[31:0], quo_r[31]};
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      neg_nxt  = dividend[31] ^ divisor[31];
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend[31] ? (~dividend + 32'd1) : dividend;
      dvs_nxt  = divisor[31] ? (~divisor + 32'd1) : divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 32'd1) : quo_r;

endmodule

[design/integer_stack_machine_step_unit.sv]
// channel  | direction | handshake          | payload
// in       | input     | in_valid/in_ready   | in_data    (ism_pkg::in_item_t)
// out      | output    | out_valid/out_ready | out_data   (ism_pkg::out_item_t)
// cfg      | input     | cfg_we              | cfg_wdata  (program length)
// Most instructions go from transfer to result through two stack memory reads
// (top, then second) in S_RD1 and S_RD2 and the execute step S_EXEC; the next
// transfer is taken back in S_IDLE. Divide adds a pass through the bit-serial divider.
// After reset a pass zeroes the local store with in_ready low.
// A result waiting on out_ready holds S_EXEC or S_DIV; no new item is taken meanwhile.
module integer_stack_machine_step_unit #(
  parameter int STACK_DEPTH = ism_pkg::STACK_DEPTH_DEF,
  parameter int LOCAL_DEPTH = ism_pkg::LOCAL_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ism_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ism_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);

  import ism_pkg::*;

  `include "integer_stack_machine_step_unit_defines.svh"

  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int LAW = (LOCAL_DEPTH > 1) ? $clog2(LOCAL_DEPTH) : 1;

  state_t state_r, state_nxt;
  in_item_t op_r;
  logic [CW-1:0]  cnt_r;
  logic [15:0]    lp_r, plen_r;
  logic [1:0]     flag_r;
  logic           stopped_r;
  logic [LAW-1:0] clr_r;
  logic [31:0]    b_r, lrd_r;
  logic           out_valid_r;
  out_item_t      out_r;

  logic [31:0]    s_rdata, l_rdata;
  logic [SAW-1:0] s_raddr, s_waddr;
  logic           s_we;
  logic [31:0]    s_wdata;
  logic           l_we;
  logic [LAW-1:0] l_waddr;
  logic [31:0]    l_wdata;

  logic        div_start, div_done;
  logic [31:0] div_q;
  logic [31:0] a_val;
  logic [63:0] prod;

  logic [2:0]  st;
  logic        push, cond, halt, is_div, need_div, show_v, wr_local, upd_flag, jump;
  logic [1:0]  pops, new_flag;
  logic [31:0] r_alu, r_val, show_d;
  logic        lrange_ok, jrange_ok;
  logic [CW:0] left;
  logic [16:0] nl17;
  logic        out_free, fin, in_fire, sel_top;
  logic [CW-1:0] rd_cnt;

  ism_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  ism_ram #(.WIDTH(32), .DEPTH(LOCAL_DEPTH)) u_local (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(op_r.operand[LAW-1:0]), .rdata(l_rdata)
  );

  ism_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(a_val), .divisor(b_r), .done(div_done), .quotient(div_q)
  );

  assign a_val   = s_rdata;
  assign prod    = a_val * b_r;
  assign in_fire = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign rd_cnt  = sel_top ? (cnt_r - CW'(1)) : (cnt_r - CW'(2));
  assign s_raddr = rd_cnt[SAW-1:0];

  always_comb begin
    st = ST_OK;
    push = 1'b0;
    pops = 2'd0;
    cond = 1'b0;
    halt = 1'b0;
    is_div = 1'b0;
    show_v = 1'b0;
    show_d = '0;
    wr_local = 1'b0;
    upd_flag = 1'b0;
    new_flag = FLAG_EQ;
    r_alu = '0;
    lrange_ok = !op_r.operand[31] && ($unsigned(op_r.operand) < 32'(LOCAL_DEPTH));
    jrange_ok = !op_r.operand[31] && ($unsigned(op_r.operand) < {16'd0, plen_r});
    case (op_r.req_type)
      OP_PUSH, OP_PUSH2: begin
        r_alu = op_r.operand;
        push = 1'b1;
      end
      OP_READ_IN: begin
        r_alu = op_r.input_value;
        push = 1'b1;
      end
      OP_POP: pops = 2'd1;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP, OP_AND, OP_OR: begin
        if (cnt_r < CW'(2)) begin
          st = ST_UNDER;
        end else begin
          pops = 2'd2;
          push = (op_r.req_type != OP_CMP);
          case (op_r.req_type)
            OP_ADD: r_alu = a_val + b_r;
            OP_SUB: r_alu = a_val - b_r;
            OP_MUL: r_alu = prod[31:0];
            OP_DIV: begin
              is_div = 1'b1;
              if (b_r == 32'd0) begin
                st = ST_DIVZ;
              end
            end
            OP_CMP: begin
              upd_flag = 1'b1;
              if (a_val == b_r) begin
                new_flag = FLAG_EQ;
              end else if ($signed(a_val) > $signed(b_r)) begin
                new_flag = FLAG_GT;
              end else begin
                new_flag = FLAG_LT;
              end
            end
            OP_AND: r_alu = {31'd0, (a_val != 32'd0) && (b_r != 32'd0)};
            default: r_alu = {31'd0, (a_val != 32'd0) || (b_r != 32'd0)};
          endcase
        end
      end
      OP_NOT: begin
        if (cnt_r < CW'(1)) begin
          st = ST_UNDER;
        end else begin
          r_alu = {31'd0, b_r == 32'd0};
          pops = 2'd1;
          push = 1'b1;
        end
      end
      OP_SHOW_TOP, OP_SHOW20, OP_SHOW21: begin
        if (cnt_r != '0) begin
          show_v = 1'b1;
          show_d = b_r;
        end
      end
      OP_SAVE_LOCAL: begin
        if (!lrange_ok) begin
          st = ST_LOCAL;
        end else if (cnt_r < CW'(1)) begin
          st = ST_UNDER;
        end else begin
          wr_local = 1'b1;
          pops = 2'd1;
        end
      end
      OP_LOAD: begin
        if (!lrange_ok) begin
          st = ST_LOCAL;
        end else begin
          r_alu = lrd_r;
          push = 1'b1;
        end
      end
      OP_JMP: cond = 1'b1;
      OP_JNZ, OP_JNE: cond = (flag_r != FLAG_EQ);
      OP_JZ, OP_JE: cond = (flag_r == FLAG_EQ);
      OP_JGE: cond = (flag_r == FLAG_GT) || (flag_r == FLAG_EQ);
      OP_JG: cond = (flag_r == FLAG_GT);
      OP_JLE: cond = (flag_r == FLAG_LT) || (flag_r == FLAG_EQ);
      OP_JL: cond = (flag_r == FLAG_LT);
      OP_NOP1B, OP_NOP1C, OP_NOP1F, OP_NOP22, OP_NOP23: ;
      OP_HALT: halt = 1'b1;
      default: st = ST_UNSUP;
    endcase
    jump = 1'b0;
    if (st == ST_OK && cond) begin
      if (!jrange_ok) begin
        st = ST_JUMP;
      end else begin
        jump = 1'b1;
      end
    end
    if (st == ST_OK && cnt_r < CW'(pops)) begin
      st = ST_UNDER;
    end
    left = {1'b0, cnt_r} - (CW + 1)'(pops);
    if (st == ST_OK && push && left >= (CW + 1)'(STACK_DEPTH)) begin
      st = ST_OVER;
    end
    need_div = is_div && (st == ST_OK) && !stopped_r;
    r_val = is_div ? div_q : r_alu;
    nl17 = {1'b0, lp_r} + 17'd1;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (clr_r == LAW'(LOCAL_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_fire) state_nxt = S_RD1;
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  state_nxt = S_EXEC;
      S_EXEC: begin
        if (need_div) begin
          state_nxt = S_DIV;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV:  if (div_done && out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == S_IDLE);
    sel_top   = (state_r == S_RD1);
    div_start = (state_r == S_EXEC) && need_div;
    fin       = ((state_r == S_EXEC) && !need_div && out_free) ||
                ((state_r == S_DIV) && div_done && out_free);
  end

  always_comb begin
    s_we    = fin && !stopped_r && st == ST_OK && !halt && push;
    s_waddr = left[SAW-1:0];
    s_wdata = r_val;
    if (state_r == S_CLR) begin
      l_we    = 1'b1;
      l_waddr = clr_r;
      l_wdata = '0;
    end else begin
      l_we    = fin && !stopped_r && st == ST_OK && wr_local;
      l_waddr = op_r.operand[LAW-1:0];
      l_wdata = b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      cnt_r       <= '0;
      lp_r        <= '0;
      flag_r      <= FLAG_EQ;
      stopped_r   <= 1'b0;
      plen_r      <= PLEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_r <= clr_r + LAW'(1);
      end
      if (cfg_we) begin
        plen_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready && !fin) begin
        out_valid_r <= 1'b0;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
        if (stopped_r) begin
          out_r <= '{status: ST_OK, next_line: lp_r, halted: 1'b1, show_valid: 1'b0,
                     show_value: '0, stack_count: 9'(cnt_r)};
        end else if (st != ST_OK) begin
          stopped_r <= 1'b1;
          out_r <= '{status: st, next_line: lp_r, halted: 1'b1, show_valid: 1'b0,
                     show_value: '0, stack_count: 9'(cnt_r)};
        end else if (halt) begin
          stopped_r <= 1'b1;
          out_r <= '{status: ST_OK, next_line: lp_r, halted: 1'b1, show_valid: show_v,
                     show_value: show_d, stack_count: 9'(cnt_r)};
        end else begin
          cnt_r <= left[CW-1:0] + CW'(push);
          if (upd_flag) begin
            flag_r <= new_flag;
          end
          if (jump) begin
            lp_r <= op_r.operand[15:0];
          end else begin
            lp_r <= nl17[15:0];
            if (nl17 >= {1'b0, plen_r}) begin
              stopped_r <= 1'b1;
            end
          end
          out_r <= '{status: ST_OK,
                     next_line: jump ? op_r.operand[15:0] : nl17[15:0],
                     halted: !jump && (nl17 >= {1'b0, plen_r}),
                     show_valid: show_v, show_value: show_d,
                     stack_count: 9'(left[CW-1:0] + CW'(push))};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_data;
    end
    if (state_r == S_RD2) begin
      b_r   <= s_rdata;
      lrd_r <= l_rdata;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ISM_ASSERT_NEXT(a_stop_sticky, stopped_r, stopped_r, "stopped flag dropped")
  `ISM_ASSERT_NOW(a_clr_blocks, state_r == S_CLR, !in_ready, "input taken during clear")
  `ISM_ASSERT_NEXT(a_fire_reads, in_fire, state_r == S_RD1, "transfer did not start read")
  `ISM_ASSERT_NEXT(a_div_busy, div_start, !div_done, "divider done right after start")

endmodule
